/* sv/cdq_pkg.sv */
`default_nettype none

package cdq_pkg;

    // Field widths fixed by the item format
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned ACT_W  = 3;

    // Build defaults
    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned CAP_RESET = 1024;

    // Action codes; codes 5 to 7 are undefined and are refused
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LOOK       = 3'd4
    } t_action;

    // Item sequencer: take item and write, read both ends, load result
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_WB   = 3'b100
    } t_state;

endpackage

`default_nettype wire

/* sv/cdq_if.sv */
`default_nettype none

// Request channel: one action per item
interface cdq_req_if;
    import cdq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [WORD_W-1:0]   data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink   (input valid, input action, input data_in, output ready);
endinterface

// Response channel: deque status after the action
interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic [WORD_W-1:0]   front_word;
    logic [WORD_W-1:0]   back_word;
    logic [CNT_W-1:0]    entry_count;
    logic                empty_flag;
    logic                full_flag;

    modport source (output valid, output accepted, output front_word, output back_word,
                    output entry_count, output empty_flag, output full_flag, input ready);
    modport sink   (input valid, input accepted, input front_word, input back_word,
                    input entry_count, input empty_flag, input full_flag, output ready);
endinterface

`default_nettype wire

/* sv/cdq_ram.sv */
`default_nettype none

// Ring store: one write port, two registered read ports
module cdq_ram #(
    parameter  int unsigned DEPTH = cdq_pkg::DEPTH_DEF,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [cdq_pkg::WORD_W-1:0] i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_rd_addr_a,
    input  wire logic [AW-1:0]             i_rd_addr_b,
    output      logic [cdq_pkg::WORD_W-1:0] o_rd_data_a,
    output      logic [cdq_pkg::WORD_W-1:0] o_rd_data_b
);
    import cdq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

/* sv/circular_deque.sv */
`default_nettype none
// circular_deque: double-ended queue of 32-bit words in a ring store.
// Request channel i_req carries an action (push front, push back, pop front,
// pop back, look) and a word; response channel o_rsp returns one item per
// request: accepted, front and back words, count, empty and full flags.
// Pushes are refused when full, pops when empty; empty ends read as 0.
// Capacity is written through i_cfg_we/i_cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce; 0 is taken
// as 1 and values above DEPTH as DEPTH, and the write empties the deque.
// An item is taken in S_IDLE (indices move, push word written), both ends
// are read from the store in S_RD, and the result is loaded into the output
// register in S_WB. A new item is taken only after the previous one has passed
// the write / read / load sequence through the single store; the next item is
// taken while the previous result still waits in the output register.
// If the receiver stalls, the sequencer holds at the load step until the
// output register frees, and i_req.ready stays low meanwhile.
// Reset (i_rst_n low, synchronous) empties the deque and sets capacity to
// 1024 (or DEPTH if smaller); store contents are not cleared.
module circular_deque #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [cdq_pkg::CNT_W-1:0] i_cfg_data,
    cdq_req_if.sink                        i_req,
    cdq_rsp_if.source                      o_rsp
);
    import cdq_pkg::*;

    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned CAP_MAX = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam int unsigned CAP_RST = (DEPTH > CAP_RESET) ? CAP_RESET : DEPTH;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cap;
    logic [AW-1:0]      r_front, n_front;
    logic [AW-1:0]      r_back, n_back;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ok, n_ok;

    logic               r_out_valid;
    logic               r_out_ok;
    logic [WORD_W-1:0]  r_out_front;
    logic [WORD_W-1:0]  r_out_back;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_empty;
    logic               r_out_full;

    logic               in_fire;
    logic               out_load;
    logic [CNT_W-1:0]   cfg_cap;
    logic [CNT_W-1:0]   cfg_nz;
    logic [AW-1:0]      cap_last;
    logic [AW-1:0]      prev_front, next_front, prev_back, next_back;
    logic               has_room, has_item;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  rd_front, rd_back;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_WB) && (!r_out_valid || o_rsp.ready);

    // effective capacity of a config write
    assign cfg_nz  = (i_cfg_data == '0) ? CNT_W'(1) : i_cfg_data;
    assign cfg_cap = (cfg_nz > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cfg_nz;

    // ring neighbors within the active capacity
    assign cap_last   = AW'(r_cap - CNT_W'(1));
    assign prev_front = (r_front == '0) ? cap_last : r_front - AW'(1);
    assign next_front = (r_front == cap_last) ? '0 : r_front + AW'(1);
    assign prev_back  = (r_back == '0) ? cap_last : r_back - AW'(1);
    assign next_back  = (r_back == cap_last) ? '0 : r_back + AW'(1);
    assign has_room   = (r_count != r_cap);
    assign has_item   = (r_count != '0);

    // action decode: new indices, count and store write
    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_back;
        unique case (t_action'(i_req.action))
            ACT_PUSH_FRONT: begin
                if (has_room) begin
                    n_front = prev_front;
                    wr_addr = prev_front;
                    wr_en   = in_fire;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (has_room) begin
                    n_back  = next_back;
                    wr_addr = r_back;
                    wr_en   = in_fire;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (has_item) begin
                    n_front = next_front;
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (has_item) begin
                    n_back  = prev_back;
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            ACT_LOOK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // sequencer: the write lands in S_IDLE, before the store reads in S_RD, so no forwarding
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_RD;
            S_RD:    n_state = S_WB;
            S_WB:    if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state and deque indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CNT_W'(CAP_RST);
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap   <= cfg_cap;
                r_front <= '0;
                r_back  <= '0;
                r_count <= '0;
            end else if (in_fire) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
                r_ok    <= n_ok;
            end
        end
    end

    cdq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_req.data_in),
        .i_rd_en     (r_state == S_RD),
        .i_rd_addr_a (r_front),
        .i_rd_addr_b (prev_back),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_front <= has_item ? rd_front : '0;
            r_out_back  <= has_item ? rd_back : '0;
            r_out_count <= r_count;
            r_out_empty <= !has_item;
            r_out_full  <= (r_count == r_cap);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.accepted    = r_out_ok;
    assign o_rsp.front_word  = r_out_front;
    assign o_rsp.back_word   = r_out_back;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.empty_flag  = r_out_empty;
    assign o_rsp.full_flag   = r_out_full;

`ifndef SYNTHESIS
    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("held count exceeds capacity");

    a_idx_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_front) < r_cap) && (CNT_W'(r_back) < r_cap))
        else $error("ring index outside active capacity");

    a_fire_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_RD))
        else $error("accepted item not followed by store read");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |->
            (r_out_front == '0) && (r_out_back == '0) && (r_out_count == '0))
        else $error("empty result carries nonzero fields");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> r_out_valid && $stable(r_out_count))
        else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire
